// ----- hdl/tick_task_scheduler_core_macros.svh -----
// ----------------------------------------------------------------------------
// tick_task_scheduler_core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_SCHEDULER_CORE_MACROS_SVH
`define TICK_TASK_SCHEDULER_CORE_MACROS_SVH

// prop must hold at every clock edge out of reset
`define TTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true out of reset
`define TTS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg
// Types, codes and sizes shared by the tick task scheduler modules.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int CNT_W          = 4;
    localparam int CD_W           = 16;
    localparam int SLOT_W         = 3;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDED    = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_RELEASED = 2'd2
    } kind_t;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic add_take;
        logic add_full;
        logic tick_apply;
        logic flush;
    } tts_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic at_end;
        logic slot_free;
        logic rel_hit;
        logic pend_valid;
        logic push_ok;
    } tts_stat_t;

endpackage

// ----- hdl/tts_ram.sv -----
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-port RAM, one access per cycle (write and read share the address), registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tts_ctrl.sv -----
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: slot scan for add, read/execute per slot for tick, final flush.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      task_valid,
    output logic      task_stall,
    input  tts_stat_t stat,
    output tts_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ADD   = 5'b00010,
        ST_RD    = 5'b00100,
        ST_EX    = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        task_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (task_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.is_tick ? ST_RD : ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (stat.slot_free)
                begin
                    if (stat.push_ok)
                    begin
                        cmd.add_take = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (stat.at_end)
                begin
                    if (stat.push_ok)
                    begin
                        cmd.add_full = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                // a second release needs the output register for the held one
                if (!(stat.rel_hit && stat.pend_valid && !stat.push_ok))
                begin
                    cmd.tick_apply = 1'b1;
                    if (stat.at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.push_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tts_datapath.sv -----
// ----------------------------------------------------------------------------
// tts_datapath
// Slot table (flag flops, countdown and period RAMs), held release, output reg.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    localparam int IDX_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              action,
    input  logic [CD_W-1:0]   start_delay,
    input  logic [CD_W-1:0]   period,
    output logic              evt_valid,
    input  logic              evt_stall,
    output logic [1:0]        kind,
    output logic [SLOT_W-1:0] slot,
    output logic              last,
    input  tts_cmd_t          cmd,
    output tts_stat_t         stat
);

    logic [CD_W-1:0]       delay_reg;
    logic [CD_W-1:0]       period_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [TASK_SLOTS-1:0] used_reg;
    logic [TASK_SLOTS-1:0] due_reg;
    logic [CNT_W-1:0]      n_reg;
    logic                  pend_valid_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic                  evt_valid_reg;
    kind_t                 kind_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  last_reg;

    logic [CD_W-1:0]         cd_q;
    logic [CD_W-1:0]         per_q;
    logic [CD_W-1:0]         cd_new;
    logic                    cd_zero;
    logic                    cur_used;
    logic                    due_new;
    logic                    rel_hit;
    logic                    cd_we;
    logic [IDX_W+SLOT_W-1:0] idx_ext;
    logic [SLOT_W-1:0]       idx_slot;
    logic                    push_ok;
    logic                    push_en;
    kind_t                   push_kind;
    logic [SLOT_W-1:0]       push_slot;
    logic                    push_last;

    tts_ram #(.WIDTH(CD_W), .DEPTH(TASK_SLOTS)) u_cd_ram (
        .clk   (clk),
        .we    (cd_we),
        .addr  (idx_reg),
        .wdata (cmd.add_take ? delay_reg : cd_new),
        .rdata (cd_q)
    );

    tts_ram #(.WIDTH(CD_W), .DEPTH(TASK_SLOTS)) u_per_ram (
        .clk   (clk),
        .we    (cmd.add_take),
        .addr  (idx_reg),
        .wdata (period_reg),
        .rdata (per_q)
    );

    assign idx_ext  = {{SLOT_W{1'b0}}, idx_reg};
    assign idx_slot = idx_ext[SLOT_W-1:0];
    assign cur_used = used_reg[idx_reg];
    assign cd_zero  = (cd_q == '0);
    assign cd_new   = cd_zero ? (per_q - CD_W'(1)) : (cd_q - CD_W'(1));
    assign due_new  = cd_zero | due_reg[idx_reg];
    assign rel_hit  = cur_used & due_new & (n_reg < CNT_W'(MAX_RESULTS));
    assign cd_we    = cmd.add_take | (cmd.tick_apply & cur_used);
    assign push_ok  = !evt_valid_reg || !evt_stall;

    always_comb
    begin
        push_en   = 1'b0;
        push_kind = KIND_RELEASED;
        push_slot = pend_slot_reg;
        push_last = 1'b0;
        if (cmd.add_take)
        begin
            push_en   = 1'b1;
            push_kind = KIND_ADDED;
            push_slot = idx_slot;
            push_last = 1'b1;
        end
        else if (cmd.add_full)
        begin
            push_en   = 1'b1;
            push_kind = KIND_FULL;
            push_slot = '0;
            push_last = 1'b1;
        end
        else if (cmd.tick_apply && rel_hit && pend_valid_reg)
        begin
            push_en = 1'b1;
        end
        else if (cmd.flush)
        begin
            push_en   = 1'b1;
            push_last = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            delay_reg  <= start_delay;
            period_reg <= period;
        end
        if (cmd.tick_apply && rel_hit)
        begin
            pend_slot_reg <= idx_slot;
        end
        if (push_en)
        begin
            kind_reg <= push_kind;
            slot_reg <= push_slot;
            last_reg <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            used_reg       <= '0;
            due_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
                n_reg   <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.add_take)
            begin
                used_reg[idx_reg] <= 1'b1;
                due_reg[idx_reg]  <= 1'b0;
            end
            if (cmd.tick_apply && cur_used)
            begin
                if (rel_hit)
                begin
                    due_reg[idx_reg] <= 1'b0;
                    if (per_q == '0)
                    begin
                        used_reg[idx_reg] <= 1'b0;
                    end
                    n_reg          <= n_reg + CNT_W'(1);
                    pend_valid_reg <= 1'b1;
                end
                else
                begin
                    due_reg[idx_reg] <= due_new;
                end
            end
            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_en)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    assign evt_valid = evt_valid_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

    assign stat.is_tick    = (action == ACT_TICK);
    assign stat.at_end     = (idx_reg == IDX_W'(TASK_SLOTS - 1));
    assign stat.slot_free  = !cur_used;
    assign stat.rel_hit    = rel_hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.push_ok    = push_ok;

endmodule

// ----- hdl/tick_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// tick_task_scheduler_core
// Time-triggered task table: add claims the first free slot, tick counts
// down every used slot and releases due tasks in slot order, up to MAX_RESULTS.
//
//   channel | signals                                   | role
//   task    | task_valid, task_stall, action,           | add / tick in
//           | start_delay, period                       |
//   evt     | evt_valid, evt_stall, kind, slot, last    | results out
//
// Add: one slot flag checked per cycle; the result waits while evt is stalled.
// Tick: after the accept, each slot needs a RAM read then an update, and a
// final flush state pushes the held release.
// One item at a time; a stalled evt channel can hold the scan in place.
// Reset clears slot and due flags and control state; countdown and period RAMs are not cleared.
// ----------------------------------------------------------------------------
module tick_task_scheduler_core import tts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              task_valid,
    output logic              task_stall,
    input  logic              action,
    input  logic [CD_W-1:0]   start_delay,
    input  logic [CD_W-1:0]   period,
    output logic              evt_valid,
    input  logic              evt_stall,
    output logic [1:0]        kind,
    output logic [SLOT_W-1:0] slot,
    output logic              last
);

    tts_cmd_t  cmd;
    tts_stat_t stat;

    tts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_stall (task_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tts_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .start_delay (start_delay),
        .period      (period),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .kind        (kind),
        .slot        (slot),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- hdl/tts_checker.sv -----
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the scheduler's results and handshakes.
// ----------------------------------------------------------------------------
`include "tick_task_scheduler_core_macros.svh"

module tts_checker import tts_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              task_valid,
    input logic              task_stall,
    input logic              action,
    input logic              evt_valid,
    input logic              evt_stall,
    input logic [1:0]        kind,
    input logic [SLOT_W-1:0] slot,
    input logic              last
);

    `TTS_ASSERT_NEVER(a_kind_code, evt_valid && kind != KIND_ADDED && kind != KIND_FULL && kind != KIND_RELEASED, "undefined result kind")
    `TTS_ASSERT(a_full_form, evt_valid && kind == KIND_FULL |-> slot == '0 && last, "table-full result malformed")
    `TTS_ASSERT(a_add_last, evt_valid && kind != KIND_RELEASED |-> last, "add transaction result not marked last")
    `TTS_ASSERT(a_add_busy, task_valid && !task_stall && action == ACT_ADD |=> task_stall, "add transaction not held off")
    `TTS_ASSERT(a_evt_hold, evt_valid && evt_stall |=> evt_valid && $stable(kind) && $stable(slot) && $stable(last), "stalled result changed")

endmodule

bind tick_task_scheduler_core tts_checker u_tts_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tick_task_scheduler_core. A local copy of the task
// table predicts every event that an accepted add or tick must cause. A
// monitor compares each accepted event field by field with the oldest
// prediction. Traffic is a short directed set followed by random add/tick
// mixes under several idle and stall patterns. One long receiver hold fills
// the block, and one sender pause drains it completely.
// ----------------------------------------------------------------------------
module tb;
    import tts_pkg::*;

    localparam int NSLOTS     = TASK_SLOTS_DEF;
    localparam int TAIL_CYC   = 2 * NSLOTS + 24;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } sched_event_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              task_valid  = 1'b0;
    logic              task_stall;
    logic              action      = ACT_ADD;
    logic [CD_W-1:0]   start_delay = '0;
    logic [CD_W-1:0]   period      = '0;
    logic              evt_valid;
    logic              evt_stall   = 1'b0;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              last;

    // local copy of the task table
    logic            tbl_used   [NSLOTS];
    logic [CD_W-1:0] tbl_count  [NSLOTS];
    logic [CD_W-1:0] tbl_reload [NSLOTS];
    logic            tbl_due    [NSLOTS];

    sched_event_t pending_events[$];

    int errors        = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int add_count     = 0;
    int tick_count    = 0;
    int full_count    = 0;
    int release_count = 0;

    tick_task_scheduler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .task_valid  (task_valid),
        .task_stall  (task_stall),
        .action      (action),
        .start_delay (start_delay),
        .period      (period),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .kind        (kind),
        .slot        (slot),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("tb: ERROR %s", msg);
        errors++;
    endtask

    function automatic void predict_events(input logic act, input logic [CD_W-1:0] dly,
                                           input logic [CD_W-1:0] per);
        sched_event_t ev;
        int           n;
        bit           found;
        n     = 0;
        found = 1'b0;
        if (act == ACT_ADD)
        begin
            add_count++;
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (!found && !tbl_used[i])
                begin
                    found         = 1'b1;
                    tbl_used[i]   = 1'b1;
                    tbl_count[i]  = dly;
                    tbl_reload[i] = per;
                    tbl_due[i]    = 1'b0;
                    ev.kind = KIND_ADDED;
                    ev.slot = SLOT_W'(i);
                    ev.last = 1'b1;
                    pending_events.push_back(ev);
                end
            end
            if (!found)
            begin
                full_count++;
                ev.kind = KIND_FULL;
                ev.slot = '0;
                ev.last = 1'b1;
                pending_events.push_back(ev);
            end
        end
        else
        begin
            tick_count++;
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (tbl_used[i])
                begin
                    if (tbl_count[i] != '0)
                        tbl_count[i] = tbl_count[i] - 1'b1;
                    else
                    begin
                        tbl_due[i]   = 1'b1;
                        tbl_count[i] = tbl_reload[i] - 1'b1;
                    end
                end
            end
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (tbl_used[i] && tbl_due[i] && n < MAX_RESULTS)
                begin
                    tbl_due[i] = 1'b0;
                    ev.kind = KIND_RELEASED;
                    ev.slot = SLOT_W'(i);
                    ev.last = 1'b0;
                    pending_events.push_back(ev);
                    n++;
                    release_count++;
                    if (tbl_reload[i] == '0)
                        tbl_used[i] = 1'b0;
                end
            end
            if (n > 0)
                pending_events[pending_events.size() - 1].last = 1'b1;
        end
    endfunction

    // event checker and predictor feed
    always @(posedge clk)
    begin
        sched_event_t e;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_events.size() == 0)
                flag_error($sformatf("unexpected event kind=%0d slot=%0d last=%0d",
                                     kind, slot, last));
            else
            begin
                e = pending_events.pop_front();
                if (kind !== e.kind)
                    flag_error($sformatf("kind got %0d want %0d", kind, e.kind));
                if (slot !== e.slot)
                    flag_error($sformatf("slot got %0d want %0d", slot, e.slot));
                if (last !== e.last)
                    flag_error($sformatf("last got %0d want %0d", last, e.last));
            end
        end
        if (rst_n && task_valid && !task_stall)
            predict_events(action, start_delay, period);
    end

    // receiver: random stall plus an optional long hold
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            evt_stall <= 1'b1;
            hold_left--;
        end
        else
            evt_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((task_valid && !task_stall) || (evt_valid && !evt_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: watchdog expired, %0d events outstanding", pending_events.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [CD_W-1:0] dly,
                             input logic [CD_W-1:0] per);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            task_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        task_valid  <= 1'b1;
        action      <= act;
        start_delay <= dly;
        period      <= per;
        do @(posedge clk); while (task_stall);
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 40)
            send_item(ACT_ADD, CD_W'($urandom_range(0, 6)), '0);
        else
            send_item(ACT_TICK, CD_W'($urandom), CD_W'($urandom));
    endtask

    task automatic drain();
        task_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(ACT_TICK, '1, '1);
        for (int i = 0; i < NSLOTS; i++)
            send_item(ACT_ADD, '0, '0);
        send_item(ACT_ADD, 16'd5, 16'd5);
        send_item(ACT_TICK, '0, '0);
        send_item(ACT_TICK, 16'h5a5a, 16'ha5a5);
        send_item(ACT_ADD, '1, '1);
        send_item(ACT_ADD, 16'd1, 16'd2);
        send_item(ACT_ADD, 16'd0, 16'd3);
        send_item(ACT_ADD, 16'd2, 16'd0);
        repeat (4) send_item(ACT_TICK, CD_W'($urandom), CD_W'($urandom));
        drain();
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_stall, input int n);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        repeat (n) send_random_item();
        drain();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 300;
        repeat (12) send_random_item();
        drain();
    endtask

    task automatic test_sender_pause();
        idle_pct  = 6;
        stall_pct = 6;
        repeat (10) send_random_item();
        drain();
        repeat (10) send_random_item();
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_used[i]   = 1'b0;
            tbl_count[i]  = '0;
            tbl_reload[i] = '0;
            tbl_due[i]    = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(0, 0, 70);
        test_random_traffic(50, 0, 70);
        test_random_traffic(0, 50, 70);
        test_random_traffic(6, 6, 70);
        test_backpressure();
        test_sender_pause();

        if (pending_events.size() != 0)
            flag_error($sformatf("%0d events never arrived", pending_events.size()));
        $display("tb: %0d adds (%0d refused as full), %0d ticks, %0d releases checked",
                 add_count, full_count, tick_count, release_count);
        $display("tb: idle/stall mixes, long output hold and full drain exercised");
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
